FILE: design/vr_pkg.sv
// shared widths, lane count and sideband record for the vector reflection pipeline
// no dependencies
package vr_pkg;

  localparam int unsigned COMP_W   = 32;                 // one vector component
  localparam int unsigned LANES    = 3;                  // x, y, z
  localparam int unsigned PROD_W   = 2 * COMP_W;         // f_i*n_i, n_i*n_i
  localparam int unsigned DOT_W    = PROD_W + 2;         // signed sum of three products
  localparam int unsigned MAG_W    = PROD_W;             // |f.n| and n.n
  localparam int unsigned NUM_W    = MAG_W + COMP_W + 1; // 2*|f.n|*|n_i|
  localparam int unsigned QUO_W    = 34;                 // |q_i| <= 2*|f| < 2^33
  localparam int unsigned QS_W     = QUO_W + 2;          // rounded, signed quotient
  localparam int unsigned RES_W    = QS_W + 1;           // quotient minus incident
  localparam int unsigned FRONT_STG = 4;
  localparam int unsigned BACK_STG  = 2;
  localparam int unsigned PIPE_STG  = FRONT_STG + QUO_W + BACK_STG;

  localparam int unsigned TUSER_INVALID = 0;
  localparam int unsigned TUSER_SAT     = 1;

  typedef logic signed [COMP_W-1:0] comp_t;

  // per item data that rides alongside the divider lanes
  typedef struct packed {
    logic [LANES-1:0][COMP_W-1:0] f;     // incident components
    logic [LANES-1:0]             neg;   // quotient sign per lane
    logic                         inv;   // zero length incident or normal
  } side_t;

endpackage

FILE: design/vr_front.sv
// front end: dot products, normal energy and the per lane division numerators
// depends on vr_pkg
module vr_front (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  vr_pkg::comp_t [vr_pkg::LANES-1:0]           f_i,
  input  vr_pkg::comp_t [vr_pkg::LANES-1:0]           n_i,
  output logic [vr_pkg::LANES-1:0][vr_pkg::NUM_W-1:0] num_o,
  output logic [vr_pkg::MAG_W-1:0]                    den_o,
  output vr_pkg::side_t                               side_o
);

  // stage 1: products
  logic [vr_pkg::LANES-1:0][vr_pkg::COMP_W-1:0] f1_q, n1_q;
  logic [vr_pkg::LANES-1:0][vr_pkg::PROD_W-1:0] pf1_q, pn1_q;
  logic                                         inv1_q;
  // stage 2: sums
  logic [vr_pkg::LANES-1:0][vr_pkg::COMP_W-1:0] f2_q, nm2_q;
  logic [vr_pkg::MAG_W-1:0]                     dmag2_q, s2_q;
  logic [vr_pkg::LANES-1:0]                     neg2_q;
  logic                                         inv2_q;
  // stage 3: split products
  logic [vr_pkg::LANES-1:0][vr_pkg::PROD_W-1:0] ph3_q, pl3_q;
  logic [vr_pkg::MAG_W-1:0]                     s3_q;
  vr_pkg::side_t                                side3_q;
  // stage 4: numerators
  logic [vr_pkg::LANES-1:0][vr_pkg::NUM_W-1:0]  num4_q;
  logic [vr_pkg::MAG_W-1:0]                     s4_q;
  vr_pkg::side_t                                side4_q;

  logic signed [vr_pkg::PROD_W-1:0] pf_d [vr_pkg::LANES];
  logic signed [vr_pkg::PROD_W-1:0] pn_d [vr_pkg::LANES];
  logic signed [vr_pkg::DOT_W-1:0]  dot_d;
  logic signed [vr_pkg::DOT_W-1:0]  dabs_d;
  logic [vr_pkg::MAG_W-1:0]         s_d;
  logic [vr_pkg::LANES-1:0][vr_pkg::COMP_W-1:0] nm_d;
  logic [vr_pkg::LANES-1:0]         nneg_d;
  logic [vr_pkg::LANES-1:0][vr_pkg::NUM_W-2:0] sum_d;
  logic                             fz_d, nz_d;

  always_comb begin
    fz_d = 1'b1;
    nz_d = 1'b1;
    for (int i = 0; i < vr_pkg::LANES; i++) begin
      pf_d[i] = $signed(f_i[i]) * $signed(n_i[i]);
      pn_d[i] = $signed(n_i[i]) * $signed(n_i[i]);
      if (f_i[i] != '0) fz_d = 1'b0;
      if (n_i[i] != '0) nz_d = 1'b0;
    end
  end

  always_comb begin
    dot_d = '0;
    s_d   = '0;
    for (int i = 0; i < vr_pkg::LANES; i++) begin
      dot_d  = dot_d + vr_pkg::DOT_W'($signed(pf1_q[i]));
      s_d    = s_d + pn1_q[i];
      nneg_d[i] = n1_q[i][vr_pkg::COMP_W-1];
      nm_d[i]   = nneg_d[i] ? (~n1_q[i] + 1'b1) : n1_q[i];
    end
    dabs_d = dot_d[vr_pkg::DOT_W-1] ? -dot_d : dot_d;
  end

  always_comb begin
    for (int i = 0; i < vr_pkg::LANES; i++) begin
      sum_d[i] = {ph3_q[i], {vr_pkg::COMP_W{1'b0}}}
               + {{vr_pkg::COMP_W{1'b0}}, pl3_q[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < vr_pkg::LANES; i++) begin
        f1_q[i]  <= f_i[i];
        n1_q[i]  <= n_i[i];
        pf1_q[i] <= pf_d[i];
        pn1_q[i] <= pn_d[i];
        f2_q[i]  <= f1_q[i];
        nm2_q[i] <= nm_d[i];
        neg2_q[i] <= dot_d[vr_pkg::DOT_W-1] ^ nneg_d[i];
        ph3_q[i] <= dmag2_q[vr_pkg::MAG_W-1:vr_pkg::COMP_W] * nm2_q[i];
        pl3_q[i] <= dmag2_q[vr_pkg::COMP_W-1:0] * nm2_q[i];
        num4_q[i] <= {sum_d[i], 1'b0};
      end
      inv1_q  <= fz_d | nz_d;
      dmag2_q <= dabs_d[vr_pkg::MAG_W-1:0];
      s2_q    <= s_d;
      inv2_q  <= inv1_q;
      s3_q    <= s2_q;
      side3_q <= '{f: f2_q, neg: neg2_q, inv: inv2_q};
      s4_q    <= s3_q;
      side4_q <= side3_q;
    end
  end

  assign num_o  = num4_q;
  assign den_o  = s4_q;
  assign side_o = side4_q;

endmodule

FILE: design/vr_div.sv
// one divider lane: restoring division, one quotient bit per pipeline stage
// depends on vr_pkg
module vr_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [vr_pkg::NUM_W-1:0]   num_i,
  input  logic [vr_pkg::MAG_W-1:0]   den_i,
  output logic [vr_pkg::QUO_W-1:0]   quo_o,
  output logic [vr_pkg::MAG_W-1:0]   rem_o,
  output logic [vr_pkg::MAG_W-1:0]   den_o
);

  localparam int unsigned QW = vr_pkg::QUO_W;
  localparam int unsigned MW = vr_pkg::MAG_W;

  logic [MW-1:0] rem_s [QW+1];
  logic [QW-1:0] low_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic [MW-1:0] den_s [QW+1];

  // quotient fits in QW bits, so the top numerator bits start below the divisor
  assign rem_s[0] = MW'(num_i[vr_pkg::NUM_W-1:QW]);
  assign low_s[0] = num_i[QW-1:0];
  assign quo_s[0] = '0;
  assign den_s[0] = den_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;
    assign trial = {rem_s[k], low_s[k][QW-1]};
    assign diff  = trial - {1'b0, den_s[k]};
    assign ge    = trial >= {1'b0, den_s[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1] <= ge ? diff[MW-1:0] : trial[MW-1:0];
        low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
        quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
        den_s[k+1] <= den_s[k];
      end
    end
  end

  assign quo_o = quo_s[QW];
  assign rem_o = rem_s[QW];
  assign den_o = den_s[QW];

endmodule

FILE: design/vr_back.sv
// back end: round half away from zero, apply sign, subtract incident, saturate
// depends on vr_pkg
module vr_back (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic [vr_pkg::LANES-1:0][vr_pkg::QUO_W-1:0] quo_i,
  input  logic [vr_pkg::LANES-1:0][vr_pkg::MAG_W-1:0] rem_i,
  input  logic [vr_pkg::MAG_W-1:0]                    den_i,
  input  vr_pkg::side_t                               side_i,
  output logic [vr_pkg::LANES-1:0][vr_pkg::COMP_W-1:0] res_o,
  output logic                                        invalid_o,
  output logic                                        sat_o
);

  logic [vr_pkg::LANES-1:0][vr_pkg::QS_W-1:0]   qs1_q;
  vr_pkg::side_t                                side1_q;
  logic [vr_pkg::LANES-1:0][vr_pkg::COMP_W-1:0] res_q;
  logic                                         inv_q, sat_q;

  logic [vr_pkg::LANES-1:0][vr_pkg::QS_W-1:0]   qs_d;
  logic [vr_pkg::LANES-1:0][vr_pkg::COMP_W-1:0] res_d;
  logic                                         sat_d;
  logic [vr_pkg::QS_W-1:0]                      qr;
  logic signed [vr_pkg::RES_W-1:0]              diff;
  logic [vr_pkg::RES_W-vr_pkg::COMP_W:0]        top;

  always_comb begin
    for (int i = 0; i < vr_pkg::LANES; i++) begin
      qr = {2'b00, quo_i[i]}
         + vr_pkg::QS_W'({rem_i[i], 1'b0} >= {1'b0, den_i});
      qs_d[i] = side_i.neg[i] ? (~qr + 1'b1) : qr;
    end
  end

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < vr_pkg::LANES; i++) begin
      diff = vr_pkg::RES_W'($signed(qs1_q[i]))
           - vr_pkg::RES_W'($signed(side1_q.f[i]));
      top  = diff[vr_pkg::RES_W-1:vr_pkg::COMP_W-1];
      if (!top[vr_pkg::RES_W-vr_pkg::COMP_W] && (top != '0)) begin
        res_d[i] = {1'b0, {(vr_pkg::COMP_W-1){1'b1}}};
        sat_d    = 1'b1;
      end else if (top[vr_pkg::RES_W-vr_pkg::COMP_W] && (top != '1)) begin
        res_d[i] = {1'b1, {(vr_pkg::COMP_W-1){1'b0}}};
        sat_d    = 1'b1;
      end else begin
        res_d[i] = diff[vr_pkg::COMP_W-1:0];
      end
    end
    if (side1_q.inv) begin
      res_d = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qs1_q   <= qs_d;
      side1_q <= side_i;
      res_q   <= res_d;
      inv_q   <= side1_q.inv;
      sat_q   <= sat_d;
    end
  end

  assign res_o     = res_q;
  assign invalid_o = inv_q;
  assign sat_o     = sat_q;

endmodule

FILE: design/vector_reflection_top.sv
// top level of the vector reflection pipeline, stream ports in and out
// depends on vr_pkg, vr_front, vr_div, vr_back
//
// reflects an incident vector f about a normal n (both signed q16.16, the
// normal need not be unit length): r = 2*(f.n)/(n.n)*n - f, computed exactly
// on the raw integers with each quotient rounded half away from zero, then
// f subtracted and each component saturated to 32 bits. a zero incident or
// zero normal gives a zero vector with the invalid flag. the block is a
// 40 stage pipeline: four front stages (products, sums, split products,
// numerators), 34 divider stages that each retire one quotient bit for all
// three lanes, and two back stages (round and sign, subtract and saturate).
// one transaction is accepted every cycle while the output side keeps
// taking results. when a finished result is held back the whole pipeline
// freezes, bubbles included, and the input stalls with it until the
// output side takes the result.
module vector_reflection_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // reflected_x, reflected_y, reflected_z
  output logic [95:0]  m_axis_tdata,
  // invalid, saturated
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned LANES = vr_pkg::LANES;
  localparam int unsigned CW    = vr_pkg::COMP_W;
  localparam int unsigned QW    = vr_pkg::QUO_W;
  localparam int unsigned NSTG  = vr_pkg::PIPE_STG;

  logic [NSTG-1:0] vld_q;
  logic            en;

  vr_pkg::comp_t [LANES-1:0] f_in, n_in;
  logic [LANES-1:0][vr_pkg::NUM_W-1:0]  num;
  logic [vr_pkg::MAG_W-1:0]             den;
  vr_pkg::side_t                        side_front;
  vr_pkg::side_t                        side_q [QW];
  logic [LANES-1:0][QW-1:0]             quo;
  logic [LANES-1:0][vr_pkg::MAG_W-1:0]  rem;
  logic [LANES-1:0][vr_pkg::MAG_W-1:0]  den_out;
  logic [LANES-1:0][CW-1:0]             res;
  logic                                 invalid, sat;

  // the whole pipeline steps unless a finished result is being held
  assign en            = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;

  // unpack the slave payload, first field in the low bits
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      f_in[i] = s_axis_tdata[i*CW +: CW];
      n_in[i] = s_axis_tdata[(i+LANES)*CW +: CW];
    end
  end

  // valid bits travel with the data, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  vr_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .f_i    (f_in),
    .n_i    (n_in),
    .num_o  (num),
    .den_o  (den),
    .side_o (side_front)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[l]),
      .den_i (den),
      .quo_o (quo[l]),
      .rem_o (rem[l]),
      .den_o (den_out[l])
    );
  end

  // sideband delay line matching the divider depth
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_front;
      for (int k = 1; k < QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  vr_back u_back (
    .clk_i     (clk_i),
    .en_i      (en),
    .quo_i     (quo),
    .rem_i     (rem),
    .den_i     (den_out[0]),
    .side_i    (side_q[QW-1]),
    .res_o     (res),
    .invalid_o (invalid),
    .sat_o     (sat)
  );

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = res;
  always_comb begin
    m_axis_tuser                        = '0;
    m_axis_tuser[vr_pkg::TUSER_INVALID] = invalid;
    m_axis_tuser[vr_pkg::TUSER_SAT]     = sat;
  end

endmodule

FILE: design/vr_checker.sv
// port level checks for the vector reflection top, attached by bind
// depends on vr_pkg, vector_reflection_top
module vr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // zero length input gives a zero vector and no saturation
  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[vr_pkg::TUSER_INVALID] |->
      m_axis_tdata == '0 && !m_axis_tuser[vr_pkg::TUSER_SAT])
    else $error("invalid result not cleared");

  // a clamped result shows a range limit in some component
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[vr_pkg::TUSER_SAT] |->
      m_axis_tdata[31:0] == 32'h7fffffff || m_axis_tdata[31:0] == 32'h80000000 ||
      m_axis_tdata[63:32] == 32'h7fffffff || m_axis_tdata[63:32] == 32'h80000000 ||
      m_axis_tdata[95:64] == 32'h7fffffff || m_axis_tdata[95:64] == 32'h80000000)
    else $error("saturated flag without a clamped component");

  // input is never blocked while the output is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind vector_reflection_top vr_checker u_vr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
